### hw/rtl/jse_pkg.sv
`default_nettype none
package jse_pkg;

   localparam logic [7:0] QUOTE_CH  = 8'h22;
   localparam logic [7:0] BSLASH_CH = 8'h5C;
   localparam logic [7:0] SLASH_CH  = 8'h2F;
   localparam logic [7:0] U_CH      = 8'h75;
   localparam logic [7:0] ZERO_CH   = 8'h30;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [7:0] BS_CODE  = 8'h08;
   localparam logic [7:0] TAB_CODE = 8'h09;
   localparam logic [7:0] LF_CODE  = 8'h0A;
   localparam logic [7:0] FF_CODE  = 8'h0C;
   localparam logic [7:0] CR_CODE  = 8'h0D;

   localparam logic [7:0] B_CH = 8'h62;
   localparam logic [7:0] F_CH = 8'h66;
   localparam logic [7:0] N_CH = 8'h6E;
   localparam logic [7:0] R_CH = 8'h72;
   localparam logic [7:0] T_CH = 8'h74;

   localparam int unsigned MAX_RUN = 8;
   localparam int unsigned IDX_W   = $clog2(MAX_RUN);
   localparam int unsigned LEN_W   = IDX_W + 1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_byte;
      logic       last_byte;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UNICODE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] body;
      logic       open_quote;
      logic       close_quote;
   } desc_type;

   typedef struct packed {
      logic avail;
      logic full;
   } qstat_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = ZERO_CH + {4'd0, nib};
      end else begin
         res = 8'h61 + {4'd0, nib - 4'd10};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/json_string_escaper.sv
// Channel   Direction  Beat                 Handshake
// req       in         jse_pkg::req_type    push / full
// rsp       out        jse_pkg::rsp_type    pop / empty
// csr       in         escape_slash bit     csr_valid / csr_ready
//
// A plain byte yields one output byte, a short escape two, a control byte six; quotes
// add one each. The back end emits one byte per cycle while rsp is not held.
// Reset is synchronous and clears the queue, sequencer and escape_slash.
// Input stalls only when the descriptor queue of QUEUE_DEPTH entries is full.
`default_nettype none
module json_string_escaper #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                 logic clock,
   input  wire                 logic reset,
   input  wire                 logic push,
   output                      logic full,
   input  wire jse_pkg::req_type   req_beat,
   output                      logic empty,
   input  wire                 logic pop,
   output      jse_pkg::rsp_type   rsp_beat,
   input  wire                 logic csr_valid,
   output                      logic csr_ready,
   input  wire                 logic csr_wdata
);

   jse_pkg::desc_type  new_desc;
   jse_pkg::desc_type  head_desc;
   jse_pkg::qstat_type q_stat;
   logic               desc_pop;

   assign full = q_stat.full;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .beat      (req_beat),
      .desc      (new_desc)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (new_desc),
      .rd_en   (desc_pop),
      .rd_data (head_desc),
      .stat    (q_stat)
   );

   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .desc     (head_desc),
      .stat     (q_stat),
      .desc_pop (desc_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_beat (rsp_beat)
   );

endmodule
`default_nettype wire

### hw/rtl/jse_front.sv
`default_nettype none
module jse_front (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic csr_valid,
   output                     logic csr_ready,
   input  wire                logic csr_wdata,
   input  wire jse_pkg::req_type  beat,
   output      jse_pkg::desc_type desc
);

   logic escape_slash_ff;
   logic escape_slash_in;

   assign csr_ready = 1'b1;

   always_comb begin
      escape_slash_in = escape_slash_ff;
      if (csr_valid) begin
         escape_slash_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_slash_ff <= 1'b0;
      end else begin
         escape_slash_ff <= escape_slash_in;
      end
   end

   always_comb begin
      desc.kind        = jse_pkg::KIND_PLAIN;
      desc.body        = beat.in_byte;
      desc.open_quote  = beat.first_byte;
      desc.close_quote = beat.last_byte;
      unique case (beat.in_byte)
         jse_pkg::QUOTE_CH, jse_pkg::BSLASH_CH: begin
            desc.kind = jse_pkg::KIND_SHORT;
         end
         jse_pkg::SLASH_CH: begin
            if (escape_slash_ff) begin
               desc.kind = jse_pkg::KIND_SHORT;
            end
         end
         jse_pkg::BS_CODE: begin
            desc.kind = jse_pkg::KIND_SHORT;
            desc.body = jse_pkg::B_CH;
         end
         jse_pkg::FF_CODE: begin
            desc.kind = jse_pkg::KIND_SHORT;
            desc.body = jse_pkg::F_CH;
         end
         jse_pkg::LF_CODE: begin
            desc.kind = jse_pkg::KIND_SHORT;
            desc.body = jse_pkg::N_CH;
         end
         jse_pkg::CR_CODE: begin
            desc.kind = jse_pkg::KIND_SHORT;
            desc.body = jse_pkg::R_CH;
         end
         jse_pkg::TAB_CODE: begin
            desc.kind = jse_pkg::KIND_SHORT;
            desc.body = jse_pkg::T_CH;
         end
         default: begin
            if (beat.in_byte < jse_pkg::CTRL_LIMIT) begin
               desc.kind = jse_pkg::KIND_UNICODE;
            end
         end
      endcase
      if (beat.empty_string) begin
         desc.kind        = jse_pkg::KIND_EMPTY;
         desc.open_quote  = 1'b0;
         desc.close_quote = 1'b0;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/jse_queue.sv
`default_nettype none
module jse_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                  logic clock,
   input  wire                  logic reset,
   input  wire                  logic wr_en,
   input  wire jse_pkg::desc_type   wr_data,
   input  wire                  logic rd_en,
   output      jse_pkg::desc_type   rd_data,
   output      jse_pkg::qstat_type  stat
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   jse_pkg::desc_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign stat.avail = (count_ff != '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && stat.avail;
   assign rd_data    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/jse_back.sv
`default_nettype none
module jse_back (
   input  wire                  logic clock,
   input  wire                  logic reset,
   input  wire jse_pkg::desc_type   desc,
   input  wire jse_pkg::qstat_type  stat,
   output                       logic desc_pop,
   output                       logic empty,
   input  wire                  logic pop,
   output      jse_pkg::rsp_type    rsp_beat
);

   logic [jse_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      out_valid_ff, out_valid_in;
   jse_pkg::rsp_type          out_ff, out_in;

   logic [7:0]                body_seq [6];
   logic [2:0]                body_len;
   logic [jse_pkg::LEN_W-1:0] run_len;
   logic [jse_pkg::IDX_W-1:0] body_idx;
   logic                      advance;
   logic                      emit;
   logic                      at_end;
   logic [7:0]                cur_byte;

   assign empty    = !out_valid_ff;
   assign rsp_beat = out_ff;
   assign advance  = !out_valid_ff || pop;
   assign emit     = advance && stat.avail;

   always_comb begin
      body_seq[0] = desc.body;
      body_seq[1] = desc.body;
      body_seq[2] = jse_pkg::ZERO_CH;
      body_seq[3] = jse_pkg::ZERO_CH;
      body_seq[4] = jse_pkg::hex_char(desc.body[7:4]);
      body_seq[5] = jse_pkg::hex_char(desc.body[3:0]);
      body_len    = 3'd1;
      unique case (desc.kind)
         jse_pkg::KIND_EMPTY: begin
            body_seq[0] = jse_pkg::QUOTE_CH;
            body_seq[1] = jse_pkg::QUOTE_CH;
            body_len    = 3'd2;
         end
         jse_pkg::KIND_PLAIN: begin
            body_len = 3'd1;
         end
         jse_pkg::KIND_SHORT: begin
            body_seq[0] = jse_pkg::BSLASH_CH;
            body_len    = 3'd2;
         end
         jse_pkg::KIND_UNICODE: begin
            body_seq[0] = jse_pkg::BSLASH_CH;
            body_seq[1] = jse_pkg::U_CH;
            body_len    = 3'd6;
         end
         default: begin
            body_len = 3'd1;
         end
      endcase
   end

   always_comb begin
      run_len  = jse_pkg::LEN_W'(body_len) + jse_pkg::LEN_W'(desc.open_quote)
               + jse_pkg::LEN_W'(desc.close_quote);
      body_idx = idx_ff - jse_pkg::IDX_W'(desc.open_quote);
      at_end   = (jse_pkg::LEN_W'(idx_ff) + 1'b1) == run_len;
      cur_byte = jse_pkg::QUOTE_CH;
      if (!(desc.open_quote && idx_ff == '0) && (body_idx < body_len)) begin
         cur_byte = body_seq[body_idx];
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      desc_pop     = 1'b0;
      if (advance) begin
         out_valid_in = stat.avail;
      end
      if (emit) begin
         out_in.out_byte = cur_byte;
         out_in.run_last = at_end;
         if (at_end) begin
            idx_in   = '0;
            desc_pop = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

### hw/rtl/jse_checker.sv
`default_nettype none
module jse_checker (
   input wire                logic clock,
   input wire                logic reset,
   input wire                logic full,
   input wire                logic empty,
   input wire                logic pop,
   input wire jse_pkg::rsp_type  rsp_beat,
   input wire                logic csr_ready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queue not idle after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped while stalled");

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_beat))
      else $error("result changed while stalled");

   a_known_beat: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !$isunknown(rsp_beat))
      else $error("result beat carries unknown bits");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("config port not ready");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
   .clock     (clock),
   .reset     (reset),
   .full      (full),
   .empty     (empty),
   .pop       (pop),
   .rsp_beat  (rsp_beat),
   .csr_ready (csr_ready)
);
`default_nettype wire
